// ===== hdl/virtual_cbeta_position_assert.svh =====
// Assertion macros for the virtual beta carbon placement block.
// Expects signals named clock and reset in the including module.
`ifndef VIRTUAL_CBETA_POSITION_ASSERT_SVH
`define VIRTUAL_CBETA_POSITION_ASSERT_SVH

// same-cycle implication
`define VCB_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VCB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/vcb_pkg.sv =====
// Shared constants for the virtual beta carbon placement block.
// Used by vcb_norm and virtual_cbeta_position; depends on nothing.
package vcb_pkg;

   localparam int UFRAC       = 14;
   localparam int UNIT_W      = UFRAC + 2;
   localparam int NORM_W      = 20;
   localparam int NORM_TOP    = NORM_W - 1;
   localparam int SUM_W       = 2 * NORM_W + 2;
   localparam int SQRT_STEPS  = SUM_W / 2;
   localparam int SQ_W        = SQRT_STEPS;
   localparam int REM_W       = SQ_W + 3;
   localparam int DIV_STEPS   = UFRAC + 1;
   localparam int NUM_W       = NORM_W + UFRAC + 1;
   localparam int DREM_W      = SQ_W + 1;
   localparam int SH_W        = 5;
   localparam int NORM_STAGES = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

   localparam int BL_W       = 13;
   localparam int ANG_W      = 15;
   localparam int BL_MAX     = (2 ** BL_W) - 1;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BOND_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLE   = 2'd2;

   localparam logic [ANG_W-1:0] COS_RESET = 15'd9468;
   localparam logic [ANG_W-1:0] SIN_RESET = 15'd13371;

endpackage

// ===== hdl/vcb_norm.sv =====
// Pipelined normalizer for two integer vectors to Q2.14 unit vectors.
// Block scaling, bit-per-stage square root, bit-per-stage division.
// Depends on vcb_pkg.
module vcb_norm #(
   parameter int IN_W   = 25,
   parameter int SIDE_W = 72
) (
   input  logic                               clock,
   input  logic [vcb_pkg::NORM_STAGES-1:0]    en,
   input  logic [IN_W-1:0]                    vec_in [2][3],
   input  logic [SIDE_W-1:0]                  side_in,
   output logic [vcb_pkg::UNIT_W-1:0]         unit_out [2][3],
   output logic [1:0]                         zero_out,
   output logic [SIDE_W-1:0]                  side_out
);
   import vcb_pkg::*;

   localparam int PW      = $clog2(IN_W);
   localparam int S_SQ0   = 6;
   localparam int S_DSET  = S_SQ0 + SQRT_STEPS;
   localparam int S_DIV0  = S_DSET + 1;
   localparam int S_OUT   = S_DIV0 + DIV_STEPS;

   logic [SIDE_W-1:0] side_ff [NORM_STAGES];
   logic [1:0]        zero_ff [NORM_STAGES];
   logic              neg_ff  [NORM_STAGES-1][2][3];

   logic [IN_W-1:0]   mag0_ff [2][3];
   logic [IN_W-1:0]   mag1_ff [2][3];
   logic [IN_W-1:0]   top1_ff [2];
   logic [IN_W-1:0]   mag2_ff [2][3];
   logic              rsh2_ff [2];
   logic [SH_W-1:0]   amt2_ff [2];
   logic [NORM_W-1:0] mag3_ff [2][3];
   logic [NORM_W-1:0] mag4_ff [2][3];
   logic [2*NORM_W-1:0] sq4_ff [2][3];

   logic [PW-1:0]     pos_w [2];
   logic              rsh_w [2];
   logic [SH_W-1:0]   amt_w [2];
   logic [IN_W+NORM_W-1:0] wide_w [2][3];
   logic [IN_W+NORM_W-1:0] shd_w  [2][3];

   logic [SUM_W-1:0]  sx_ff    [SQRT_STEPS+1][2];
   logic [REM_W-1:0]  srem_ff  [SQRT_STEPS+1][2];
   logic [SQ_W-1:0]   sroot_ff [SQRT_STEPS+1][2];
   logic [NORM_W-1:0] smag_ff  [SQRT_STEPS+1][2][3];

   logic [NUM_W-1:0]     num_w [2][3];
   logic [DREM_W-1:0]    drem_ff [DIV_STEPS+1][2][3];
   logic [DIV_STEPS-1:0] dlow_ff [DIV_STEPS+1][2][3];
   logic [DIV_STEPS-1:0] dq_ff   [DIV_STEPS+1][2][3];
   logic [SQ_W-1:0]      ddiv_ff [DIV_STEPS+1][2];

   logic [UNIT_W-1:0] unit_ff [2][3];

   // side data, zero flags and signs travel with the item
   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side_in;
         for (int v = 0; v < 2; v++) begin
            zero_ff[0][v] <= (vec_in[v][0] == '0) && (vec_in[v][1] == '0) &&
                             (vec_in[v][2] == '0);
            for (int c = 0; c < 3; c++) begin
               neg_ff[0][v][c] <= vec_in[v][c][IN_W-1];
            end
         end
      end
      for (int k = 1; k < NORM_STAGES; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
      for (int k = 1; k < NORM_STAGES - 1; k++) begin
         if (en[k]) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         pos_w[v] = '0;
         for (int b = 0; b < IN_W; b++) begin
            if (top1_ff[v][b]) begin
               pos_w[v] = PW'(b);
            end
         end
         rsh_w[v] = (int'(pos_w[v]) >= NORM_TOP);
         amt_w[v] = rsh_w[v] ? SH_W'(int'(pos_w[v]) - NORM_TOP) :
                               SH_W'(NORM_TOP - int'(pos_w[v]));
         for (int c = 0; c < 3; c++) begin
            wide_w[v][c] = (IN_W + NORM_W)'(mag2_ff[v][c]);
            shd_w[v][c]  = rsh2_ff[v] ? (wide_w[v][c] >> amt2_ff[v]) :
                                        (wide_w[v][c] << amt2_ff[v]);
         end
      end
   end

   // magnitude, block maximum, scaling, squares, sum
   always_ff @(posedge clock) begin
      for (int v = 0; v < 2; v++) begin
         if (en[0]) begin
            for (int c = 0; c < 3; c++) begin
               mag0_ff[v][c] <= vec_in[v][c][IN_W-1] ? -vec_in[v][c] : vec_in[v][c];
            end
         end
         if (en[1]) begin
            mag1_ff[v] <= mag0_ff[v];
            if (mag0_ff[v][0] >= mag0_ff[v][1] && mag0_ff[v][0] >= mag0_ff[v][2]) begin
               top1_ff[v] <= mag0_ff[v][0];
            end else if (mag0_ff[v][1] >= mag0_ff[v][2]) begin
               top1_ff[v] <= mag0_ff[v][1];
            end else begin
               top1_ff[v] <= mag0_ff[v][2];
            end
         end
         if (en[2]) begin
            mag2_ff[v] <= mag1_ff[v];
            rsh2_ff[v] <= rsh_w[v];
            amt2_ff[v] <= amt_w[v];
         end
         for (int c = 0; c < 3; c++) begin
            if (en[3]) begin
               mag3_ff[v][c] <= NORM_W'(shd_w[v][c]);
            end
            if (en[4]) begin
               sq4_ff[v][c]  <= mag3_ff[v][c] * mag3_ff[v][c];
               mag4_ff[v][c] <= mag3_ff[v][c];
            end
         end
         if (en[5]) begin
            sx_ff[0][v]    <= SUM_W'(sq4_ff[v][0]) + SUM_W'(sq4_ff[v][1]) +
                              SUM_W'(sq4_ff[v][2]);
            srem_ff[0][v]  <= '0;
            sroot_ff[0][v] <= '0;
            smag_ff[0][v]  <= mag4_ff[v];
         end
      end
   end

   // square root, one result bit per stage
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      logic [REM_W-1:0] pre_w   [2];
      logic [REM_W-1:0] trial_w [2];

      always_comb begin
         for (int v = 0; v < 2; v++) begin
            pre_w[v]   = {srem_ff[j][v][REM_W-3:0], sx_ff[j][v][SUM_W-1 -: 2]};
            trial_w[v] = REM_W'({sroot_ff[j][v], 2'b01});
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_SQ0 + j]) begin
            for (int v = 0; v < 2; v++) begin
               sx_ff[j+1][v]   <= sx_ff[j][v] << 2;
               smag_ff[j+1][v] <= smag_ff[j][v];
               if (pre_w[v] >= trial_w[v]) begin
                  srem_ff[j+1][v]  <= pre_w[v] - trial_w[v];
                  sroot_ff[j+1][v] <= {sroot_ff[j][v][SQ_W-2:0], 1'b1};
               end else begin
                  srem_ff[j+1][v]  <= pre_w[v];
                  sroot_ff[j+1][v] <= {sroot_ff[j][v][SQ_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // rounded dividend: m * 2^14 + r / 2
   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int c = 0; c < 3; c++) begin
            num_w[v][c] = NUM_W'({smag_ff[SQRT_STEPS][v][c], {UFRAC{1'b0}}}) +
                          NUM_W'(sroot_ff[SQRT_STEPS][v] >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_DSET]) begin
         for (int v = 0; v < 2; v++) begin
            ddiv_ff[0][v] <= sroot_ff[SQRT_STEPS][v];
            for (int c = 0; c < 3; c++) begin
               drem_ff[0][v][c] <= DREM_W'(num_w[v][c] >> DIV_STEPS);
               dlow_ff[0][v][c] <= num_w[v][c][DIV_STEPS-1:0];
               dq_ff[0][v][c]   <= '0;
            end
         end
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [DREM_W-1:0] pre_w [2][3];
      logic [DREM_W-1:0] dsr_w [2];

      always_comb begin
         for (int v = 0; v < 2; v++) begin
            dsr_w[v] = DREM_W'(ddiv_ff[j][v]);
            for (int c = 0; c < 3; c++) begin
               pre_w[v][c] = {drem_ff[j][v][c][DREM_W-2:0],
                              dlow_ff[j][v][c][DIV_STEPS-1]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_DIV0 + j]) begin
            for (int v = 0; v < 2; v++) begin
               ddiv_ff[j+1][v] <= ddiv_ff[j][v];
               for (int c = 0; c < 3; c++) begin
                  dlow_ff[j+1][v][c] <= dlow_ff[j][v][c] << 1;
                  if (pre_w[v][c] >= dsr_w[v]) begin
                     drem_ff[j+1][v][c] <= pre_w[v][c] - dsr_w[v];
                     dq_ff[j+1][v][c]   <= {dq_ff[j][v][c][DIV_STEPS-2:0], 1'b1};
                  end else begin
                     drem_ff[j+1][v][c] <= pre_w[v][c];
                     dq_ff[j+1][v][c]   <= {dq_ff[j][v][c][DIV_STEPS-2:0], 1'b0};
                  end
               end
            end
         end
      end
   end

   // restore sign
   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         for (int v = 0; v < 2; v++) begin
            for (int c = 0; c < 3; c++) begin
               unit_ff[v][c] <= neg_ff[NORM_STAGES-2][v][c] ?
                                -UNIT_W'(dq_ff[DIV_STEPS][v][c]) :
                                UNIT_W'(dq_ff[DIV_STEPS][v][c]);
            end
         end
      end
   end

   assign unit_out = unit_ff;
   assign zero_out = zero_ff[NORM_STAGES-1];
   assign side_out = side_ff[NORM_STAGES-1];

endmodule

// ===== hdl/virtual_cbeta_position.sv =====
// One item per cycle sustained while rsp_stall is low.
// Depth is set by two normalizer pipelines, each a 21-stage square root and a
// 15-stage divider, plus cross product and placement stages.
// Reset clears all valid bits and loads bond length 1.524 A, cos and sin of 54.7 deg.
// Depends on vcb_pkg, vcb_norm and virtual_cbeta_position_assert.svh.
`include "virtual_cbeta_position_assert.svh"
module virtual_cbeta_position #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_WIDTH-1:0]      req_n_x,
   input  logic signed [COORD_WIDTH-1:0]      req_n_y,
   input  logic signed [COORD_WIDTH-1:0]      req_n_z,
   input  logic signed [COORD_WIDTH-1:0]      req_ca_x,
   input  logic signed [COORD_WIDTH-1:0]      req_ca_y,
   input  logic signed [COORD_WIDTH-1:0]      req_ca_z,
   input  logic signed [COORD_WIDTH-1:0]      req_c_x,
   input  logic signed [COORD_WIDTH-1:0]      req_c_y,
   input  logic signed [COORD_WIDTH-1:0]      req_c_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_cb_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_cb_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_cb_z,
   output logic                               rsp_degenerate,
   input  logic                               csr_wr_en,
   input  logic [vcb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vcb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import vcb_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int D1_W   = CW + 1;
   localparam int D2_W   = UNIT_W + 1;
   localparam int P_W    = 2 * UNIT_W;
   localparam int CR_W   = P_W + 1;
   localparam int S_W    = UNIT_W + 2;
   localparam int T_W    = S_W + ANG_W + 2;
   localparam int BT_W   = T_W + BL_W + 1;
   localparam int OFF_W  = BT_W - 2 * UFRAC + 1;
   localparam int AW     = (CW > OFF_W ? CW : OFF_W) + 1;
   localparam int CAV_W  = 3 * CW;

   localparam int N1     = 1;
   localparam int MID    = N1 + NORM_STAGES;
   localparam int N2     = MID + 1;
   localparam int X1     = N2 + NORM_STAGES;
   localparam int TAIL   = 7;
   localparam int OUT    = X1 + TAIL;
   localparam int NST    = OUT + 1;

   localparam int BL_CALC = (1524 * (2 ** FRAC_BITS) + 500) / 1000;
   localparam logic [BL_W-1:0] BL_RESET = BL_W'(BL_CALC > BL_MAX ? BL_MAX : BL_CALC);
   localparam logic signed [AW-1:0] CB_MAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [AW-1:0] CB_MIN = ~CB_MAX;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   logic [BL_W-1:0]  bl_ff;
   logic [ANG_W-1:0] cos_ff;
   logic [ANG_W-1:0] sin_ff;

   logic signed [CW-1:0] n_w [3];
   logic signed [CW-1:0] ca_w [3];
   logic signed [CW-1:0] c_w [3];

   logic [D1_W-1:0]  n1_vec [2][3];
   logic [CW-1:0]    ca0_ff [3];
   logic [UNIT_W-1:0] n1_unit [2][3];
   logic [1:0]       n1_zero;
   logic [CAV_W-1:0] n1_side;

   logic [D2_W-1:0]  n2_vec [2][3];
   logic             deg_mid_ff;
   logic [CAV_W-1:0] ca_mid_ff;
   logic [UNIT_W-1:0] n2_unit [2][3];
   logic [1:0]       n2_zero;
   logic [CAV_W:0]   n2_side;

   logic signed [UNIT_W-1:0] pl_w [3];
   logic signed [UNIT_W-1:0] mn_w [3];
   logic signed [UNIT_W-1:0] a_w [3];
   logic signed [UNIT_W-1:0] b_w [3];

   logic signed [CW-1:0]     cca_ff [TAIL][3];
   logic                     cdeg_ff [TAIL];
   logic signed [UNIT_W-1:0] cpl_ff [3][3];

   logic signed [P_W-1:0]  xp_ff [6];
   logic signed [CR_W-1:0] cr_ff [3];
   logic [CR_W-1:0]        cmag_w [3];
   logic [CR_W-1:0]        crnd_w [3];
   logic signed [S_W-1:0]  s_ff [3];
   logic signed [T_W-1:0]  cp_ff [3];
   logic signed [T_W-1:0]  sp_ff [3];
   logic signed [T_W-1:0]  t_ff [3];
   logic signed [BT_W-1:0] bt_ff [3];
   logic [BT_W-1:0]        bmag_w [3];
   logic [BT_W-1:0]        brnd_w [3];
   logic signed [OFF_W-1:0] off_ff [3];
   logic signed [AW-1:0]   sum_w [3];
   logic signed [CW-1:0]   cb_w [3];

   logic signed [CW-1:0] cb_ff [3];
   logic                 deg_ff;

   assign n_w  = '{req_n_x, req_n_y, req_n_z};
   assign ca_w = '{req_ca_x, req_ca_y, req_ca_z};
   assign c_w  = '{req_c_x, req_c_y, req_c_z};

   // a stage advances when it or any later stage is empty, or the output drains
   always_comb begin
      for (int k = 0; k < NST; k++) begin
         en[k] = !rsp_stall || (|(~v_ff >> k));
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_ff  <= BL_RESET;
         cos_ff <= COS_RESET;
         sin_ff <= SIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BOND_LENGTH: bl_ff  <= csr_data[BL_W-1:0];
            CSR_COS_ANGLE:   cos_ff <= csr_data[ANG_W-1:0];
            CSR_SIN_ANGLE:   sin_ff <= csr_data[ANG_W-1:0];
            default: ;
         endcase
      end
   end

   // backbone difference vectors
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int c = 0; c < 3; c++) begin
            n1_vec[0][c] <= D1_W'(ca_w[c]) - D1_W'(n_w[c]);
            n1_vec[1][c] <= D1_W'(ca_w[c]) - D1_W'(c_w[c]);
            ca0_ff[c]    <= ca_w[c];
         end
      end
   end

   vcb_norm #(
      .IN_W   (D1_W),
      .SIDE_W (CAV_W)
   ) u_norm_bond (
      .clock    (clock),
      .en       (en[N1 +: NORM_STAGES]),
      .vec_in   (n1_vec),
      .side_in  ({ca0_ff[2], ca0_ff[1], ca0_ff[0]}),
      .unit_out (n1_unit),
      .zero_out (n1_zero),
      .side_out (n1_side)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_w[c] = n1_unit[0][c];
         b_w[c] = n1_unit[1][c];
      end
   end

   // difference and sum of the bond unit vectors
   always_ff @(posedge clock) begin
      if (en[MID]) begin
         for (int c = 0; c < 3; c++) begin
            n2_vec[0][c] <= D2_W'(a_w[c]) - D2_W'(b_w[c]);
            n2_vec[1][c] <= D2_W'(a_w[c]) + D2_W'(b_w[c]);
         end
         deg_mid_ff <= |n1_zero;
         ca_mid_ff  <= n1_side;
      end
   end

   vcb_norm #(
      .IN_W   (D2_W),
      .SIDE_W (CAV_W + 1)
   ) u_norm_frame (
      .clock    (clock),
      .en       (en[N2 +: NORM_STAGES]),
      .vec_in   (n2_vec),
      .side_in  ({deg_mid_ff, ca_mid_ff}),
      .unit_out (n2_unit),
      .zero_out (n2_zero),
      .side_out (n2_side)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mn_w[c] = n2_unit[0][c];
         pl_w[c] = n2_unit[1][c];
      end
   end

   // carry CA, degenerate flag and plus vector down the tail
   always_ff @(posedge clock) begin
      if (en[X1]) begin
         for (int c = 0; c < 3; c++) begin
            cca_ff[0][c] <= n2_side[c*CW +: CW];
            cpl_ff[0][c] <= pl_w[c];
         end
         cdeg_ff[0] <= n2_side[CAV_W] || (|n2_zero);
      end
      for (int k = 1; k < TAIL; k++) begin
         if (en[X1 + k]) begin
            cca_ff[k]  <= cca_ff[k-1];
            cdeg_ff[k] <= cdeg_ff[k-1];
         end
      end
      for (int k = 1; k < 3; k++) begin
         if (en[X1 + k]) begin
            cpl_ff[k] <= cpl_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cmag_w[c] = cr_ff[c][CR_W-1] ? -cr_ff[c] : cr_ff[c];
         crnd_w[c] = (cmag_w[c] + (CR_W'(1) << (UFRAC - 1))) >> UFRAC;
         bmag_w[c] = bt_ff[c][BT_W-1] ? -bt_ff[c] : bt_ff[c];
         brnd_w[c] = (bmag_w[c] + (BT_W'(1) << (2 * UFRAC - 1))) >> (2 * UFRAC);
         sum_w[c]  = AW'(cca_ff[TAIL-1][c]) + AW'(off_ff[c]);
         if (sum_w[c] > CB_MAX) begin
            cb_w[c] = CB_MAX[CW-1:0];
         end else if (sum_w[c] < CB_MIN) begin
            cb_w[c] = CB_MIN[CW-1:0];
         end else begin
            cb_w[c] = sum_w[c][CW-1:0];
         end
      end
   end

   // cross product, placement and saturation
   always_ff @(posedge clock) begin
      if (en[X1]) begin
         xp_ff[0] <= pl_w[1] * mn_w[2];
         xp_ff[1] <= pl_w[2] * mn_w[1];
         xp_ff[2] <= pl_w[2] * mn_w[0];
         xp_ff[3] <= pl_w[0] * mn_w[2];
         xp_ff[4] <= pl_w[0] * mn_w[1];
         xp_ff[5] <= pl_w[1] * mn_w[0];
      end
      if (en[X1 + 1]) begin
         for (int c = 0; c < 3; c++) begin
            cr_ff[c] <= CR_W'(xp_ff[2*c]) - CR_W'(xp_ff[2*c+1]);
         end
      end
      for (int c = 0; c < 3; c++) begin
         if (en[X1 + 2]) begin
            s_ff[c] <= cr_ff[c][CR_W-1] ? -S_W'(crnd_w[c]) : S_W'(crnd_w[c]);
         end
         if (en[X1 + 3]) begin
            cp_ff[c] <= $signed({1'b0, cos_ff}) * cpl_ff[2][c];
            sp_ff[c] <= $signed({1'b0, sin_ff}) * s_ff[c];
         end
         if (en[X1 + 4]) begin
            t_ff[c] <= cp_ff[c] - sp_ff[c];
         end
         if (en[X1 + 5]) begin
            bt_ff[c] <= $signed({1'b0, bl_ff}) * t_ff[c];
         end
         if (en[X1 + 6]) begin
            off_ff[c] <= bt_ff[c][BT_W-1] ? -OFF_W'(brnd_w[c]) : OFF_W'(brnd_w[c]);
         end
         if (en[OUT]) begin
            cb_ff[c] <= cdeg_ff[TAIL-1] ? cca_ff[TAIL-1][c] : cb_w[c];
         end
      end
      if (en[OUT]) begin
         deg_ff <= cdeg_ff[TAIL-1];
      end
   end

   assign rsp_cb_x       = cb_ff[0];
   assign rsp_cb_y       = cb_ff[1];
   assign rsp_cb_z       = cb_ff[2];
   assign rsp_degenerate = deg_ff;

   `VCB_ASSERT_IMPLY(a_stall_only_full, req_stall, rsp_stall && (&v_ff), "input stalled with a free stage")
   `VCB_ASSERT_NEXT(a_accept_captured, req_valid && !req_stall, v_ff[0], "accepted item not captured")
   `VCB_ASSERT_NEXT(a_bond_write, csr_wr_en && (csr_index == CSR_BOND_LENGTH), bl_ff == $past(csr_data[BL_W-1:0]), "bond length write lost")

endmodule
